/* rtl/core/gf28_pkg.sv */
// shared types, operation codes and helpers for the gf(2^8) arithmetic unit
`timescale 1ns / 1ps

package gf28_pkg;

    localparam int FieldDegree = 8;

    typedef logic [FieldDegree-1:0] elem_t;
    typedef logic [FieldDegree:0]   poly_t;
    typedef logic [3:0]             deg_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_INV = 2'd3
    } op_t;

    typedef struct packed {
        op_t   operation;
        elem_t operand_a;
        elem_t operand_b;
    } cmd_t;

    // index of the highest set bit, zero for an all-zero word
    function automatic deg_t poly_deg(input poly_t p);
        deg_t d;
        d = '0;
        for (int i = 0; i <= FieldDegree; i++) begin
            if (p[i]) begin
                d = deg_t'(i);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/core/gf28_core.sv */
// sequencer and shared shift-and-xor datapath for add, multiply, divide and inverse
`timescale 1ns / 1ps

module gf28_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_valid,
    output logic             start_ready,
    input  gf28_pkg::cmd_t   cmd,
    input  gf28_pkg::elem_t  modulus_low,
    output logic             res_valid,
    input  logic             res_take,
    output gf28_pkg::elem_t  res_data
);
    import gf28_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EUC,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t     state_reg;
    op_t        op_reg;
    elem_t      a_reg;
    elem_t      b_reg;
    elem_t      acc_reg;
    logic [2:0] cnt_reg;
    poly_t      r1_reg;
    poly_t      r_reg;
    poly_t      t1_reg;
    poly_t      tacc_reg;
    elem_t      res_reg;

    poly_t m9;
    deg_t  d1;
    deg_t  dr;
    deg_t  sh;
    logic  r_ge;
    poly_t r1_sh;
    poly_t t1_sh;
    poly_t inv_full;
    elem_t inv;
    poly_t mul_shl;
    poly_t mul_red;
    elem_t mul_next;
    elem_t x_in;

    always_comb begin
        m9       = {1'b1, modulus_low};
        d1       = poly_deg(r1_reg);
        dr       = poly_deg(r_reg);
        r_ge     = (r_reg != '0) && (dr >= d1);
        sh       = dr - d1;
        r1_sh    = r1_reg << sh;
        t1_sh    = t1_reg << sh;
        inv_full = t1_reg[FieldDegree] ? (t1_reg ^ m9) : t1_reg;
        inv      = inv_full[FieldDegree-1:0];
        mul_shl  = {acc_reg, 1'b0};
        mul_red  = mul_shl[FieldDegree] ? (mul_shl ^ m9) : mul_shl;
        mul_next = mul_red[FieldDegree-1:0] ^ (b_reg[cnt_reg] ? a_reg : '0);
        x_in     = (cmd.operation == OP_INV) ? cmd.operand_a : cmd.operand_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start_valid) begin
                        op_reg   <= cmd.operation;
                        a_reg    <= cmd.operand_a;
                        b_reg    <= cmd.operand_b;
                        acc_reg  <= '0;
                        cnt_reg  <= 3'd7;
                        r1_reg   <= {1'b0, x_in};
                        r_reg    <= m9;
                        t1_reg   <= poly_t'(1);
                        tacc_reg <= '0;
                        case (cmd.operation)
                            OP_ADD: begin
                                res_reg   <= cmd.operand_a ^ cmd.operand_b;
                                state_reg <= ST_DONE;
                            end
                            OP_MUL: begin
                                state_reg <= ST_MUL;
                            end
                            default: begin
                                if (x_in == '0) begin
                                    res_reg   <= '0;
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_EUC;
                                end
                            end
                        endcase
                    end
                end
                ST_EUC: begin
                    if (r1_reg[FieldDegree:1] == '0) begin
                        // remainder of degree below one: bezout coefficient is final
                        if (op_reg == OP_INV) begin
                            res_reg   <= inv;
                            state_reg <= ST_DONE;
                        end else begin
                            b_reg     <= inv;
                            state_reg <= ST_MUL;
                        end
                    end else if (r_ge) begin
                        r_reg    <= r_reg ^ r1_sh;
                        tacc_reg <= tacc_reg ^ t1_sh;
                    end else begin
                        r1_reg   <= r_reg;
                        r_reg    <= r1_reg;
                        t1_reg   <= tacc_reg;
                        tacc_reg <= t1_reg;
                    end
                end
                ST_MUL: begin
                    acc_reg <= mul_next;
                    if (cnt_reg == 3'd0) begin
                        res_reg   <= mul_next;
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                ST_DONE: begin
                    if (res_take) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign start_ready = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_DONE);
    assign res_data    = res_reg;

endmodule

/* rtl/core/gf_2_8_arithmetic_unit.sv */
// top level: gf(2^8) add, multiply, divide and inverse with configurable modulus
// add is a single xor; inverse runs euclid on the modulus and operand_a, a shift-and-xor
// or swap per step plus a finishing step; divide inverts operand_b that way, then
// multiplies by operand_a; the multiply takes its multiplier a bit per step, msb first
// one item at a time: the next beat is taken the cycle after the result reaches the output
// register; synchronous active-low reset clears control and loads the modulus 0x11b
`timescale 1ns / 1ps

module gf_2_8_arithmetic_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [8:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  gf28_pkg::elem_t       s_operand_a,
    input  gf28_pkg::elem_t       s_operand_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gf28_pkg::elem_t       m_field_result
);
    import gf28_pkg::*;

    localparam logic [8:0] ModulusReset = 9'h11B;

    elem_t field_modulus_reg;
    logic  m_valid_reg;
    elem_t m_result_reg;

    cmd_t  cmd;
    logic  core_ready;
    logic  core_res_valid;
    elem_t core_res_data;
    logic  load;

    assign cmd.operation = op_t'(s_operation);
    assign cmd.operand_a = s_operand_a;
    assign cmd.operand_b = s_operand_b;

    gf28_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (s_valid),
        .start_ready (core_ready),
        .cmd         (cmd),
        .modulus_low (field_modulus_reg),
        .res_valid   (core_res_valid),
        .res_take    (load),
        .res_data    (core_res_data)
    );

    // bit 8 of the modulus is always taken as set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_modulus_reg <= ModulusReset[7:0];
        end else if (cfg_valid) begin
            field_modulus_reg <= cfg_data[7:0];
        end
    end

    assign load = core_res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= core_res_data;
        end
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = core_ready;
    assign m_valid        = m_valid_reg;
    assign m_field_result = m_result_reg;

endmodule
